// File: rtl/core/pixel_gamma_correction_unit_defines.svh
// Assertion macros for the gamma correction unit checker.
`ifndef PIXEL_GAMMA_CORRECTION_UNIT_DEFINES_SVH
`define PIXEL_GAMMA_CORRECTION_UNIT_DEFINES_SVH

// Implication into the next cycle, disabled in reset.
`define PGC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pgc: next-cycle check failed");

// Same-cycle implication, disabled in reset.
`define PGC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pgc: same-cycle check failed");

// Check that follows reset itself.
`define PGC_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("pgc: reset check failed");

`endif

// File: rtl/core/pgc_pkg.sv
// Package: types, widths and the log distance table of the gamma unit.
`default_nettype none
package pgc_pkg;

  localparam int PIX_W   = 8;
  localparam int GAMMA_W = 16;
  localparam int LOG_FR  = 26;
  localparam int MANT_FR = 30;
  localparam int LG_W    = 31;
  localparam int DIST_W  = 29;
  localparam int GSH     = 12;
  localparam int TGT_W   = DIST_W + GSH;
  localparam int PROD_W  = DIST_W + GAMMA_W;
  localparam logic [GAMMA_W-1:0] GAMMA_RESET = 16'd4096;
  localparam logic [PIX_W-1:0]   FULL_SCALE  = 8'd255;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             end_of_image;
  } pgc_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             end_of_image_out;
  } pgc_out_t;

  // One item in flight through the search.
  typedef struct packed {
    logic             eoi;
    logic             zero;
    logic [PIX_W-1:0] r;
    logic [TGT_W-1:0] target;
  } pgc_work_t;

  typedef logic [DIST_W-1:0] dist_tab_t [256];

  // Truncated log2 in Q5.26 by repeated squaring of the mantissa.
  function automatic logic [LG_W-1:0] fixed_log2(input int unsigned x);
    int unsigned top;
    logic [63:0] m;
    logic [LOG_FR-1:0] frac;
    top  = 0;
    frac = '0;
    if (x == 0) begin
      return '0;
    end
    for (int i = 0; i < 8; i++) begin
      if (((x >> i) & 1) != 0) begin
        top = i;
      end
    end
    m = 64'(x) << (MANT_FR - top);
    for (int i = 0; i < LOG_FR; i++) begin
      m = (m * m) >> MANT_FR;
      frac = frac << 1;
      if (m >= (64'd2 << MANT_FR)) begin
        m = m >> 1;
        frac[0] = 1'b1;
      end
    end
    return {5'(top), frac};
  endfunction

  // Distance to white: LG(255) - LG(x).
  function automatic dist_tab_t build_dist();
    dist_tab_t t;
    logic [LG_W-1:0] white;
    logic [LG_W-1:0] diff;
    white = fixed_log2(255);
    for (int x = 0; x < 256; x++) begin
      diff = white - fixed_log2(x);
      t[x] = diff[DIST_W-1:0];
    end
    return t;
  endfunction

  localparam dist_tab_t DIST_TABLE = build_dist();

endpackage
`default_nettype wire

// File: rtl/core/pgc_front.sv
// Entry stage: registers the request and forms the search target.
`default_nettype none
module pgc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pgc_pkg::pgc_in_t  in_req,
  output logic                   valid,
  input  wire logic              ready_dn,
  output pgc_pkg::pgc_work_t     work
);
  import pgc_pkg::*;

  assign in_ready = !valid || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      work.eoi    <= in_req.end_of_image;
      work.zero   <= (in_req.pixel_in == '0);
      work.r      <= '0;
      work.target <= {DIST_TABLE[in_req.pixel_in], GSH'(0)};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pgc_step.sv
// One bit of the binary search: table read, then multiply and compare.
`default_nettype none
module pgc_step #(
  parameter int BIT = 7
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [pgc_pkg::GAMMA_W-1:0]   gamma,
  input  wire logic                          valid_up,
  output logic                               ready_up,
  input  wire pgc_pkg::pgc_work_t            work_up,
  output logic                               valid,
  input  wire logic                          ready_dn,
  output pgc_pkg::pgc_work_t                 work
);
  import pgc_pkg::*;

  logic              valid_a;
  logic              ready_a;
  pgc_work_t         work_a;
  logic [PIX_W-1:0]  cand_a;
  logic [DIST_W-1:0] dist_a;
  logic [PIX_W-1:0]  cand;
  logic [PROD_W-1:0] prod;
  pgc_work_t         work_next;

  assign cand     = work_up.r | PIX_W'(1 << BIT);
  assign ready_a  = !valid || ready_dn;
  assign ready_up = !valid_a || ready_a;

  // Stage A: look up the candidate's distance.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (ready_up) begin
      valid_a <= valid_up;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && valid_up) begin
      work_a <= work_up;
      cand_a <= cand;
      dist_a <= DIST_TABLE[cand];
    end
  end

  // Stage B: keep the candidate if gamma * D(cand) still reaches the target.
  assign prod = PROD_W'(gamma) * PROD_W'(dist_a);

  always_comb begin
    work_next = work_a;
    if (prod >= PROD_W'(work_a.target)) begin
      work_next.r = cand_a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_a) begin
      valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && valid_a) begin
      work <= work_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pixel_gamma_correction_unit.sv
// Top level of the gamma correction unit.
// Usage:
//   Input channel in_valid / in_stall / in_req carries one grey pixel and
//   its end-of-image mark per request. Output channel out_valid /
//   out_stall / out_req returns the corrected pixel and the copied mark.
//   gamma_we / gamma_wdata writes gamma (unsigned Q4.12); write it only
//   while no request is in flight.
//   Result = largest r with gamma * D(r) >= 4096 * D(p), D = log2 distance
//   to white from a constant table; found by an 8-step binary search.
//   Path: entry register, two stages per search bit, output
//   register. Throughput: one request per clock while the output is not
//   stalled, set by the pipeline of one 16x29 multiplier per search bit.
//   Reset: all stages empty, gamma returns to 1.0.
//   Output stall: each stage holds while its successor is full and
//   stalled; bubbles close up, and in_stall rises only when every stage
//   is occupied behind a stalled output.
`default_nettype none
module pixel_gamma_correction_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         gamma_we,
  input  wire logic [pgc_pkg::GAMMA_W-1:0]  gamma_wdata,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire pgc_pkg::pgc_in_t             in_req,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output pgc_pkg::pgc_out_t                 out_req
);
  import pgc_pkg::*;

  localparam int STEPS = PIX_W;

  logic [GAMMA_W-1:0] gamma;
  logic               in_ready;
  logic               out_ready;

  // Chain links: index 0 is the entry stage, STEPS is the last search step.
  logic      link_valid [STEPS+1];
  logic      link_ready [STEPS+1];
  pgc_work_t link_work  [STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma <= GAMMA_RESET;
    end else if (gamma_we) begin
      gamma <= gamma_wdata;
    end
  end

  assign in_stall = !in_ready;

  pgc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_req   (in_req),
    .valid    (link_valid[0]),
    .ready_dn (link_ready[0]),
    .work     (link_work[0])
  );

  // Search from the top bit down.
  for (genvar g = 0; g < STEPS; g++) begin : g_step
    pgc_step #(.BIT(STEPS - 1 - g)) u_step (
      .clk      (clk),
      .rst      (rst),
      .gamma    (gamma),
      .valid_up (link_valid[g]),
      .ready_up (link_ready[g]),
      .work_up  (link_work[g]),
      .valid    (link_valid[g+1]),
      .ready_dn (link_ready[g+1]),
      .work     (link_work[g+1])
    );
  end

  // Output register; black input forces zero.
  assign out_ready         = !out_valid || !out_stall;
  assign link_ready[STEPS] = out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= link_valid[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && link_valid[STEPS]) begin
      out_req.pixel_out        <= link_work[STEPS].zero ? '0 : link_work[STEPS].r;
      out_req.end_of_image_out <= link_work[STEPS].eoi;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/pgc_checker.sv
// Port-level checker for the gamma correction unit, with its bind.
`default_nettype none
`include "pixel_gamma_correction_unit_defines.svh"
module pgc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        gamma_we,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire pgc_pkg::pgc_in_t            in_req,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire pgc_pkg::pgc_out_t           out_req
);
  import pgc_pkg::*;

  // Pipeline is empty after reset.
  `PGC_ASSERT_RST(a_rst_empty, !out_valid)
  // A stalled result stays put.
  `PGC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_req))
  // A stalled request stays put.
  `PGC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_req))
  // Input may only be stalled when the output is blocked.
  `PGC_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall)
  // Gamma is written only with no result pending.
  `PGC_ASSERT_NOW(a_cfg_idle, gamma_we, !out_valid)

endmodule

bind pixel_gamma_correction_unit pgc_checker u_pgc_checker (.*);
`default_nettype wire
